// ===== rtl/ubx_pkg.sv =====
// Package for the UBX frame extractor: sizes, sync constants and state types.
// Used by ubx_frame_extractor; no dependencies.
package ubx_pkg;

  localparam int FRAME_MAX    = 512;
  localparam int RING_SIZE    = 4096;
  localparam int FRAME_AW     = $clog2(FRAME_MAX);
  localparam int FCOUNT_W     = $clog2(FRAME_MAX + 1);
  localparam int RING_AW      = $clog2(RING_SIZE);
  localparam int FILL_W       = $clog2(RING_SIZE + 1);
  localparam int LEN_W        = 16;
  localparam int HEADER_BYTES = 4;

  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN1,
    PH_LEN2,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_COPY
  } ctrl_t;

endpackage

// ===== rtl/ubx_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ubx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ubx_frame_extractor.sv =====
// UBX frame extractor: framer with Fletcher-8 check, frame buffer and byte ring.
// Depends on ubx_pkg and ubx_ram (frame buffer and ring memories).
// A fed byte loads the result register on acceptance; a pop of a non-empty ring loads it
// after the ring read; a byte that closes a good frame loads it once the whole frame is
// copied to the ring (one ring write per cycle while the ring has room; body from frame buffer).
// Throughput: one item at a time, taken only when idle and the result register is free.
// Reset: synchronous, clears framer, ring pointers and counters; memories are not cleared.
module ubx_frame_extractor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [7:0]                 byte_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       frame_accepted,
  output logic                       checksum_failed,
  output logic                       read_valid,
  output logic [7:0]                 read_byte,
  output logic [ubx_pkg::FILL_W-1:0] ring_fill,
  output logic [ubx_pkg::FILL_W-1:0] ring_peak,
  output logic [31:0]                good_frames,
  output logic [31:0]                bad_frames
);

  import ubx_pkg::*;

  ctrl_t               state, state_next;
  phase_t              phase, phase_next;
  logic [FCOUNT_W-1:0] count, count_next;
  logic [LEN_W-1:0]    len, len_next;
  logic [7:0]          sum_a, sum_a_next;
  logic [7:0]          sum_b, sum_b_next;
  logic [7:0]          rx_sum_a, rx_sum_a_next;
  logic [RING_AW-1:0]  head, head_next;
  logic [RING_AW-1:0]  tail, tail_next;
  logic [FILL_W-1:0]   used, used_next;
  logic [FILL_W-1:0]   high, high_next;
  logic [31:0]         good, good_next;
  logic [31:0]         bad, bad_next;
  logic [FCOUNT_W-1:0] k, k_next;
  logic [FCOUNT_W-1:0] k_last, k_last_next;

  logic                fr_we;
  logic [FRAME_AW-1:0] fr_waddr, fr_raddr;
  logic [7:0]          fr_wdata, fr_rdata;
  logic                rg_we;
  logic [RING_AW-1:0]  rg_waddr, rg_raddr;
  logic [7:0]          rg_wdata, rg_rdata;

  logic                load, res_ok, res_bad, res_rv;
  logic [7:0]          res_rb;

  logic                accept;
  logic                add;
  logic [FCOUNT_W-1:0] cnt_b;
  logic [7:0]          a_b, a_add;
  logic [LEN_W-1:0]    len_tmp;
  logic [FCOUNT_W-1:0] k_m1;
  logic [7:0]          cp_byte;

  ubx_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_frame_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  ubx_ram #(.WIDTH(8), .DEPTH(RING_SIZE)) u_ring_ram (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
    .raddr(rg_raddr), .rdata(rg_rdata)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_SYNC1;
      count    <= '0;
      len      <= '0;
      sum_a    <= '0;
      sum_b    <= '0;
      rx_sum_a <= '0;
      head     <= '0;
      tail     <= '0;
      used     <= '0;
      high     <= '0;
      good     <= '0;
      bad      <= '0;
      k        <= '0;
      k_last   <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      count    <= count_next;
      len      <= len_next;
      sum_a    <= sum_a_next;
      sum_b    <= sum_b_next;
      rx_sum_a <= rx_sum_a_next;
      head     <= head_next;
      tail     <= tail_next;
      used     <= used_next;
      high     <= high_next;
      good     <= good_next;
      bad      <= bad_next;
      k        <= k_next;
      k_last   <= k_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_accepted  <= res_ok;
      checksum_failed <= res_bad;
      read_valid      <= res_rv;
      read_byte       <= res_rb;
      ring_fill       <= used_next;
      ring_peak       <= high_next;
      good_frames     <= good_next;
      bad_frames      <= bad_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    count_next    = count;
    len_next      = len;
    sum_a_next    = sum_a;
    sum_b_next    = sum_b;
    rx_sum_a_next = rx_sum_a;
    head_next     = head;
    tail_next     = tail;
    used_next     = used;
    high_next     = high;
    good_next     = good;
    bad_next      = bad;
    k_next        = k;
    k_last_next   = k_last;

    load    = 1'b0;
    res_ok  = 1'b0;
    res_bad = 1'b0;
    res_rv  = 1'b0;
    res_rb  = 8'h00;

    // class byte starts a fresh count and fresh sums
    cnt_b   = (phase == PH_CLASS) ? '0 : count;
    a_b     = (phase == PH_CLASS) ? 8'h00 : sum_a;
    a_add   = a_b + byte_in;
    add     = (phase == PH_CLASS) || (phase == PH_ID) || (phase == PH_LEN1) ||
              (phase == PH_LEN2) || (phase == PH_PAYLOAD);
    len_tmp = {byte_in, len[7:0]};

    k_m1     = k - 1'b1;
    fr_we    = 1'b0;
    fr_waddr = cnt_b[FRAME_AW-1:0];
    fr_wdata = byte_in;
    fr_raddr = k_m1[FRAME_AW-1:0];

    cp_byte  = fr_rdata;
    rg_we    = 1'b0;
    rg_waddr = head;
    rg_wdata = cp_byte;
    rg_raddr = tail;

    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_FEED)) begin
          load = 1'b1;
          if (add) begin
            fr_we      = (cnt_b < FCOUNT_W'(FRAME_MAX));
            count_next = cnt_b + 1'b1;
            sum_a_next = a_add;
            sum_b_next = ((phase == PH_CLASS) ? 8'h00 : sum_b) + a_add;
          end
          unique case (phase)
            PH_SYNC1: phase_next = (byte_in == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: phase_next = (byte_in == SYNC_TWO) ? PH_CLASS : PH_SYNC1;
            PH_CLASS: phase_next = PH_ID;
            PH_ID:    phase_next = PH_LEN1;
            PH_LEN1: begin
              len_next   = {8'h00, byte_in};
              phase_next = PH_LEN2;
            end
            PH_LEN2: begin
              if ({1'b0, len_tmp} > (LEN_W + 1)'(FRAME_MAX - 8)) begin
                phase_next = PH_SYNC1;
                count_next = '0;
                len_next   = '0;
                sum_a_next = '0;
                sum_b_next = '0;
              end else begin
                len_next   = len_tmp;
                phase_next = (len_tmp == '0) ? PH_CKA : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              if ((LEN_W + 1)'(count) + 1'b1 >=
                  (LEN_W + 1)'(HEADER_BYTES) + {1'b0, len}) begin
                phase_next = PH_CKA;
              end
            end
            PH_CKA: begin
              rx_sum_a_next = byte_in;
              phase_next    = PH_CKB;
            end
            PH_CKB: begin
              if ((rx_sum_a == sum_a) && (byte_in == sum_b)) begin
                // result waits for the ring copy; sums and count kept for it
                load        = 1'b0;
                good_next   = good + 1'b1;
                k_next      = '0;
                k_last_next = count + FCOUNT_W'(3);
                state_next  = ST_COPY;
              end else begin
                res_bad    = 1'b1;
                bad_next   = bad + 1'b1;
                phase_next = PH_SYNC1;
                count_next = '0;
                len_next   = '0;
                sum_a_next = '0;
                sum_b_next = '0;
              end
            end
            default: begin
              phase_next = PH_SYNC1;
              count_next = '0;
              len_next   = '0;
              sum_a_next = '0;
              sum_b_next = '0;
            end
          endcase
        end else if (accept) begin
          if (used != '0) begin
            tail_next  = (tail == RING_AW'(RING_SIZE - 1)) ? '0 : tail + 1'b1;
            used_next  = used - 1'b1;
            state_next = ST_POP;
          end else begin
            load = 1'b1;
          end
        end
      end
      ST_POP: begin
        load       = 1'b1;
        res_rv     = 1'b1;
        res_rb     = rg_rdata;
        state_next = ST_IDLE;
      end
      ST_COPY: begin
        priority if (k == '0) begin
          cp_byte = SYNC_ONE;
        end else if (k == FCOUNT_W'(1)) begin
          cp_byte = SYNC_TWO;
        end else if (k == k_last) begin
          cp_byte = sum_b;
        end else if (k == k_last - 1'b1) begin
          cp_byte = sum_a;
        end else begin
          cp_byte = fr_rdata;
        end
        rg_wdata = cp_byte;
        if (used < FILL_W'(RING_SIZE)) begin
          rg_we     = 1'b1;
          head_next = (head == RING_AW'(RING_SIZE - 1)) ? '0 : head + 1'b1;
          used_next = used + 1'b1;
        end
        if (k == k_last) begin
          high_next  = (used_next > high) ? used_next : high;
          load       = 1'b1;
          res_ok     = 1'b1;
          phase_next = PH_SYNC1;
          count_next = '0;
          len_next   = '0;
          sum_a_next = '0;
          sum_b_next = '0;
          state_next = ST_IDLE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
